// ===== src/srb_pkg.sv =====
package srb_pkg;

   // Storage geometry
   localparam int MaxSlices     = 64;
   localparam int MaxSliceBytes = 1024;
   localparam int SlotW         = 6;
   localparam int OffW          = 10;
   localparam int PosW          = 7;
   localparam int IdxW          = 10;
   localparam int LenW          = 11;
   localparam int CountW        = 17;
   localparam logic [CountW-1:0] CountMax = 17'h1FFFF;

   typedef enum logic [1:0] {
      OP_INFO  = 2'd0,
      OP_BYTE  = 2'd1,
      OP_READ  = 2'd2,
      OP_RESET = 2'd3
   } op_type;

   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_FRAME    = 3'd1;
   localparam logic [2:0] STAT_RANGE    = 3'd2;
   localparam logic [2:0] STAT_DUP      = 3'd3;
   localparam logic [2:0] STAT_REPEATED = 3'd4;
   localparam logic [2:0] STAT_FULL     = 3'd5;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [23:0] frame_number;
      logic [9:0]  slice_number;
      logic [6:0]  total_slices;
      logic [16:0] total_bytes;
      logic [7:0]  payload_byte;
      logic        slice_end;
      logic [5:0]  read_position;
      logic [9:0]  read_offset;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        frame_complete;
      logic [6:0]  slices_held;
      logic [16:0] bytes_held;
      logic [7:0]  read_value;
      logic [10:0] read_slice_length;
      logic        read_ok;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_CHK,
      ST_PLACE,
      ST_FREE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INSERT,
      ST_RD_SOP,
      ST_RD_OUT,
      ST_PR_RD,
      ST_PR_LEN,
      ST_PR_EVAL,
      ST_PR_SWAP
   } state_type;

   // Write port of the sorted order store
   typedef struct packed {
      logic             idx_we;
      logic             sop_we;
      logic [SlotW-1:0] addr;
      logic [IdxW-1:0]  idx;
      logic [SlotW-1:0] sop;
   } ord_wr_type;

   // Write port of the slot length and payload stores
   typedef struct packed {
      logic             len_we;
      logic             pay_we;
      logic [SlotW-1:0] slot;
      logic [OffW-1:0]  offset;
      logic [LenW-1:0]  len;
      logic [7:0]       data;
   } dat_wr_type;

   function automatic logic is_done(input logic fk, input logic tk, input logic open,
                                    input logic rej, input logic [PosW-1:0] held,
                                    input logic [6:0] es, input logic [CountW-1:0] bc,
                                    input logic [CountW-1:0] eb);
      is_done = fk && tk && !(open && !rej) && (held == es) && (bc == eb);
   endfunction

endpackage

// ===== src/slice_reassembly_buffer_unit.sv =====
// Continuation bytes, first info, repeated or foreign info, range and frame rejects,
// container reset and reads of an incomplete frame finish in the idle state; a valid read
// goes through a slot lookup and an output state. A slice start scans the held entries,
// moves those at and above the insertion point up and inserts; a duplicate ends the scan
// and a full store ends at placement. Late info prunes slices and recounts held bytes.
// Results strobe after the final state, no receiver stall; reset clears control state.
module slice_reassembly_buffer_unit import srb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   state_type        st_ff, st_in;
   req_type          rq_ff, rq_in;
   logic             fk_ff, fk_in, tk_ff, tk_in, open_ff, open_in, rej_ff, rej_in;
   logic [23:0]      cf_ff, cf_in;
   logic [6:0]       es_ff, es_in;
   logic [CountW-1:0] eb_ff, eb_in, bc_ff, bc_in;
   logic [PosW-1:0]  held_ff, held_in, p_ff, p_in, w_ff, w_in, q_ff, q_in, qm1;
   logic [SlotW-1:0] oslot_ff, oslot_in, fs_ff, fs_in, sp_ff, sp_in, sw_ff, sw_in;
   logic [LenW-1:0]  olen_ff, olen_in;
   logic [CountW:0]  sum_ff, sum_in;
   logic [IdxW-1:0]  ix_ff, ix_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;

   ord_wr_type       ow;
   dat_wr_type       dw;
   logic [SlotW-1:0] rda, rdb, dslot, sop_a, sop_b;
   logic [OffW-1:0]  doff;
   logic [IdxW-1:0]  idx_a;
   logic [LenW-1:0]  len_q;
   logic [7:0]       pay_q;
   logic [2:0]       status;
   logic [7:0]       rv;
   logic [LenW-1:0]  rlen;
   logic             rok, fire;

   srb_order_mem u_order (
      .clock     (clock),
      .reset     (reset),
      .wr        (ow),
      .rd_a_addr (rda),
      .rd_b_addr (rdb),
      .idx_a     (idx_a),
      .sop_a     (sop_a),
      .sop_b     (sop_b)
   );

   srb_data_mem u_data (
      .clock     (clock),
      .wr        (dw),
      .rd_slot   (dslot),
      .rd_offset (doff),
      .len_q     (len_q),
      .pay_q     (pay_q)
   );

   assign qm1 = q_ff - 7'd1;

   // Sequence each request through the stores
   always_comb begin
      st_in = st_ff;  rq_in = rq_ff;  fk_in = fk_ff;  tk_in = tk_ff;
      open_in = open_ff;  rej_in = rej_ff;  cf_in = cf_ff;  es_in = es_ff;
      eb_in = eb_ff;  bc_in = bc_ff;  held_in = held_ff;  p_in = p_ff;
      w_in = w_ff;  q_in = q_ff;  oslot_in = oslot_ff;  fs_in = fs_ff;
      sp_in = sp_ff;  sw_in = sw_ff;  olen_in = olen_ff;  sum_in = sum_ff;
      ix_in = ix_ff;
      ow = '0;  dw = '0;  rda = '0;  rdb = '0;  dslot = '0;  doff = '0;
      status = STAT_OK;  rv = '0;  rlen = '0;  rok = 1'b0;  fire = 1'b0;

      case (st_ff)
         ST_IDLE: begin
            if (start) begin
               rq_in = req_data;
               case (op_type'(req_data.opcode))
                  OP_INFO: begin
                     fire = 1'b1;
                     if (!fk_ff) begin
                        fk_in = 1'b1;  cf_in = req_data.frame_number;  tk_in = 1'b1;
                        es_in = req_data.total_slices;  eb_in = req_data.total_bytes;
                        held_in = '0;  bc_in = '0;
                     end else if (req_data.frame_number != cf_ff) begin
                        status = STAT_FRAME;
                     end else if (tk_ff) begin
                        status = STAT_REPEATED;
                     end else begin
                        fire = 1'b0;
                        tk_in = 1'b1;  es_in = req_data.total_slices;
                        eb_in = req_data.total_bytes;
                        p_in = '0;  w_in = '0;  sum_in = '0;
                        st_in = ST_PR_RD;
                     end
                  end
                  OP_BYTE: begin
                     if (!open_ff) begin
                        open_in = 1'b1;
                        if (!fk_ff) begin
                           fk_in = 1'b1;  cf_in = req_data.frame_number;  tk_in = 1'b0;
                           es_in = '0;  eb_in = '0;  held_in = '0;  bc_in = '0;
                           p_in = '0;  st_in = ST_SCAN;
                        end else if (req_data.frame_number != cf_ff) begin
                           status = STAT_FRAME;  fire = 1'b1;
                           open_in = !req_data.slice_end;  rej_in = !req_data.slice_end;
                        end else if (tk_ff && (req_data.slice_number >= {3'b0, es_ff})) begin
                           status = STAT_RANGE;  fire = 1'b1;
                           open_in = !req_data.slice_end;  rej_in = !req_data.slice_end;
                        end else begin
                           p_in = '0;  st_in = ST_SCAN;
                        end
                     end else begin
                        // Append a continuation byte to the open slice
                        fire = 1'b1;
                        if (!rej_ff) begin
                           if (olen_ff < LenW'(MaxSliceBytes)) begin
                              dw.len_we = 1'b1;  dw.pay_we = 1'b1;  dw.slot = oslot_ff;
                              dw.offset = olen_ff[OffW-1:0];  dw.len = olen_ff + 11'd1;
                              dw.data = req_data.payload_byte;
                              olen_in = olen_ff + 11'd1;
                              if (tk_ff && (bc_ff != CountMax)) begin
                                 bc_in = bc_ff + 17'd1;
                              end
                           end else begin
                              status = STAT_FULL;
                           end
                        end
                        if (req_data.slice_end) begin
                           open_in = 1'b0;  rej_in = 1'b0;
                        end
                     end
                  end
                  OP_READ: begin
                     if (is_done(fk_ff, tk_ff, open_ff, rej_ff, held_ff, es_ff, bc_ff, eb_ff)
                         && ({1'b0, req_data.read_position} < held_ff)) begin
                        rda = req_data.read_position;
                        st_in = ST_RD_SOP;
                     end else begin
                        fire = 1'b1;
                     end
                  end
                  OP_RESET: begin
                     fire = 1'b1;
                     fk_in = 1'b0;  cf_in = '0;  tk_in = 1'b0;  es_in = '0;  eb_in = '0;
                     held_in = '0;  bc_in = '0;  open_in = 1'b0;  rej_in = 1'b0;
                  end
                  default: begin
                     fire = 1'b1;
                  end
               endcase
            end
         end

         // Read path: position to slot, then length and byte
         ST_RD_SOP: begin
            dslot = sop_a;
            doff = rq_ff.read_offset;
            st_in = ST_RD_OUT;
         end
         ST_RD_OUT: begin
            rlen = len_q;
            if ({1'b0, rq_ff.read_offset} < len_q) begin
               rv = pay_q;
               rok = 1'b1;
            end
            fire = 1'b1;
            st_in = ST_IDLE;
         end

         // Search the sorted order for the insertion point
         ST_SCAN: begin
            if (p_ff < held_ff) begin
               rda = p_ff[SlotW-1:0];
               st_in = ST_SCAN_CHK;
            end else begin
               st_in = ST_PLACE;
            end
         end
         ST_SCAN_CHK: begin
            if (idx_a < rq_ff.slice_number) begin
               p_in = p_ff + 7'd1;
               st_in = ST_SCAN;
            end else if (idx_a == rq_ff.slice_number) begin
               status = STAT_DUP;  fire = 1'b1;
               open_in = !rq_ff.slice_end;  rej_in = !rq_ff.slice_end;
               st_in = ST_IDLE;
            end else begin
               st_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            if (held_ff >= PosW'(MaxSlices)) begin
               status = STAT_FULL;  fire = 1'b1;
               open_in = !rq_ff.slice_end;  rej_in = !rq_ff.slice_end;
               st_in = ST_IDLE;
            end else begin
               rda = held_ff[SlotW-1:0];
               q_in = held_ff;
               st_in = ST_FREE;
            end
         end
         ST_FREE: begin
            fs_in = sop_a;
            st_in = ST_SHIFT_RD;
         end
         // Move entries at and above the insertion point up by one
         ST_SHIFT_RD: begin
            if (q_ff > p_ff) begin
               rda = qm1[SlotW-1:0];
               st_in = ST_SHIFT_WR;
            end else begin
               st_in = ST_INSERT;
            end
         end
         ST_SHIFT_WR: begin
            ow.idx_we = 1'b1;  ow.sop_we = 1'b1;  ow.addr = q_ff[SlotW-1:0];
            ow.idx = idx_a;  ow.sop = sop_a;
            q_in = qm1;
            st_in = ST_SHIFT_RD;
         end
         // Place the new slice and store its first byte
         ST_INSERT: begin
            ow.idx_we = 1'b1;  ow.sop_we = 1'b1;  ow.addr = p_ff[SlotW-1:0];
            ow.idx = rq_ff.slice_number;  ow.sop = fs_ff;
            dw.len_we = 1'b1;  dw.pay_we = 1'b1;  dw.slot = fs_ff;  dw.offset = '0;
            dw.len = 11'd1;  dw.data = rq_ff.payload_byte;
            held_in = held_ff + 7'd1;
            oslot_in = fs_ff;
            olen_in = 11'd1;
            if (tk_ff && (bc_ff != CountMax)) begin
               bc_in = bc_ff + 17'd1;
            end
            if (rq_ff.slice_end) begin
               open_in = 1'b0;  rej_in = 1'b0;
            end
            fire = 1'b1;
            st_in = ST_IDLE;
         end

         // Prune slices past the new total and recount bytes
         ST_PR_RD: begin
            if (p_ff < held_ff) begin
               rda = p_ff[SlotW-1:0];
               rdb = w_ff[SlotW-1:0];
               st_in = ST_PR_LEN;
            end else begin
               held_in = w_ff;
               bc_in = (sum_ff > {1'b0, CountMax}) ? CountMax : sum_ff[CountW-1:0];
               fire = 1'b1;
               st_in = ST_IDLE;
            end
         end
         ST_PR_LEN: begin
            ix_in = idx_a;  sp_in = sop_a;  sw_in = sop_b;
            dslot = sop_a;
            st_in = ST_PR_EVAL;
         end
         ST_PR_EVAL: begin
            if (ix_ff < {3'b0, es_ff}) begin
               sum_in = sum_ff + {7'b0, len_q};
               ow.idx_we = 1'b1;  ow.sop_we = 1'b1;  ow.addr = w_ff[SlotW-1:0];
               ow.idx = ix_ff;  ow.sop = sp_ff;
               st_in = ST_PR_SWAP;
            end else begin
               if (open_ff && !rej_ff && (sp_ff == oslot_ff)) begin
                  rej_in = 1'b1;
               end
               p_in = p_ff + 7'd1;
               st_in = ST_PR_RD;
            end
         end
         ST_PR_SWAP: begin
            // Hand the displaced free slot to the kept entry's old position
            ow.sop_we = 1'b1;  ow.addr = p_ff[SlotW-1:0];  ow.sop = sw_ff;
            w_in = w_ff + 7'd1;
            p_in = p_ff + 7'd1;
            st_in = ST_PR_RD;
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      rsp_strobe_in = fire;
      rsp_in.status = status;
      rsp_in.frame_complete = is_done(fk_in, tk_in, open_in, rej_in, held_in, es_in,
                                      bc_in, eb_in);
      rsp_in.slices_held = held_in;
      rsp_in.bytes_held = bc_in;
      rsp_in.read_value = rv;
      rsp_in.read_slice_length = rlen;
      rsp_in.read_ok = rok;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;  fk_ff <= 1'b0;  tk_ff <= 1'b0;  open_ff <= 1'b0;
         rej_ff <= 1'b0;  cf_ff <= '0;  es_ff <= '0;  eb_ff <= '0;  bc_ff <= '0;
         held_ff <= '0;  oslot_ff <= '0;  olen_ff <= '0;  rsp_strobe_ff <= 1'b0;
      end else begin
         st_ff <= st_in;  fk_ff <= fk_in;  tk_ff <= tk_in;  open_ff <= open_in;
         rej_ff <= rej_in;  cf_ff <= cf_in;  es_ff <= es_in;  eb_ff <= eb_in;
         bc_ff <= bc_in;  held_ff <= held_in;  oslot_ff <= oslot_in;
         olen_ff <= olen_in;  rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Working registers and result
   always_ff @(posedge clock) begin
      rq_ff <= rq_in;  p_ff <= p_in;  w_ff <= w_in;  q_ff <= q_in;  fs_ff <= fs_in;
      sp_ff <= sp_in;  sw_ff <= sw_in;  sum_ff <= sum_in;  ix_ff <= ix_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (st_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== src/srb_order_mem.sv =====
module srb_order_mem import srb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  ord_wr_type       wr,
   input  logic [SlotW-1:0] rd_a_addr,
   input  logic [SlotW-1:0] rd_b_addr,
   output logic [IdxW-1:0]  idx_a,
   output logic [SlotW-1:0] sop_a,
   output logic [SlotW-1:0] sop_b
);

   logic [IdxW-1:0]  idx_mem [MaxSlices];
   logic [SlotW-1:0] sop_mem [MaxSlices];

   logic [PosW-1:0]  fill_ff, fill_in;
   logic [IdxW-1:0]  idx_a_ff;
   logic [SlotW-1:0] sop_a_ff, sop_b_ff, a_addr_ff, b_addr_ff;
   logic             a_ok_ff, b_ok_ff;

   // Track the written prefix; positions beyond it read as the identity slot
   always_comb begin
      fill_in = fill_ff;
      if ((wr.idx_we || wr.sop_we) && ({1'b0, wr.addr} >= fill_ff)) begin
         fill_in = {1'b0, wr.addr} + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Write and read the order stores
   always_ff @(posedge clock) begin
      if (wr.idx_we) begin
         idx_mem[wr.addr] <= wr.idx;
      end
      if (wr.sop_we) begin
         sop_mem[wr.addr] <= wr.sop;
      end
      idx_a_ff  <= idx_mem[rd_a_addr];
      sop_a_ff  <= sop_mem[rd_a_addr];
      sop_b_ff  <= sop_mem[rd_b_addr];
      a_addr_ff <= rd_a_addr;
      b_addr_ff <= rd_b_addr;
      a_ok_ff   <= {1'b0, rd_a_addr} < fill_ff;
      b_ok_ff   <= {1'b0, rd_b_addr} < fill_ff;
   end

   assign idx_a = idx_a_ff;
   assign sop_a = a_ok_ff ? sop_a_ff : a_addr_ff;
   assign sop_b = b_ok_ff ? sop_b_ff : b_addr_ff;

endmodule

// ===== src/srb_data_mem.sv =====
module srb_data_mem import srb_pkg::*; (
   input  logic             clock,
   input  dat_wr_type       wr,
   input  logic [SlotW-1:0] rd_slot,
   input  logic [OffW-1:0]  rd_offset,
   output logic [LenW-1:0]  len_q,
   output logic [7:0]       pay_q
);

   logic [LenW-1:0] len_mem [MaxSlices];
   logic [7:0]      pay_mem [MaxSlices*MaxSliceBytes];

   // Write and read slot lengths and payload bytes
   always_ff @(posedge clock) begin
      if (wr.len_we) begin
         len_mem[wr.slot] <= wr.len;
      end
      if (wr.pay_we) begin
         pay_mem[{wr.slot, wr.offset}] <= wr.data;
      end
      len_q <= len_mem[rd_slot];
      pay_q <= pay_mem[{rd_slot, rd_offset}];
   end

endmodule
